>>> rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_PROCESSES_DEF = 16;

    localparam int TIME_W  = 24;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 5;
    localparam int PC_W    = 5;
    localparam int SLOT_W  = 4;
    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int ARR_W   = 16;
    localparam int PRI_W   = 8;

    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [PC_W-1:0]   PC_RESET  = PC_W'(1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] remaining;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_SUM
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/pps_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_table
// Process table: one write port, one registered read port. Per-entry valid
// bits make an unwritten entry read with zero remaining time.
// ----------------------------------------------------------------------------
module pps_table
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(MAX_PROCESSES)-1:0] i_wr_addr,
    input  wire t_entry                           i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(MAX_PROCESSES)-1:0] i_rd_addr,
    output t_entry                                o_rd_data
);

    t_entry                     r_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0]   r_valid;
    t_entry                     r_rd_data;
    logic                       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.remaining = '0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Priority scheduler over a process table with per-tick selection and
// completion statistics.
// ----------------------------------------------------------------------------
// A load item writes its slot in the accept cycle and busy never rises. A tick
// item holds busy high while it scans the N slots in use
// (min(process_count, MAX_PROCESSES)): the table's single read port delivers
// one slot per cycle to one shared compare unit, then ST_CALC computes the
// end time, waiting and turnaround times and ST_SUM updates the totals.
// The result strobe is high for a single cycle, the first with busy low; the
// receiver cannot stall it, so it must take every result as it comes. Every tick
// item gives exactly one result, load items give none.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_kind,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [ID_W-1:0]     i_proc_id,
    input  wire logic [BURST_W-1:0]  i_burst,
    input  wire logic [ARR_W-1:0]    i_arrival,
    input  wire logic [PRI_W-1:0]    i_priority_req,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [PC_W-1:0]     i_cfg_data,
    output logic                     o_result_valid,
    output logic [TIME_W-1:0]        o_tick_time,
    output logic                     o_ran,
    output logic [SLOT_W-1:0]        o_chosen_slot,
    output logic [ID_W-1:0]          o_chosen_id,
    output logic                     o_finished,
    output logic [TIME_W-1:0]        o_wait_time,
    output logic [TIME_W-1:0]        o_turnaround,
    output logic                     o_all_done,
    output logic [SUM_W-1:0]         o_total_wait,
    output logic [SUM_W-1:0]         o_total_turnaround
);

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CW    = $clog2(MAX_PROCESSES + 1);
    localparam int XW    = 9;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_PROCESSES);

    t_state              r_state, n_state;
    logic [PC_W-1:0]     r_pc;
    logic [TIME_W-1:0]   r_time;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_wait_sum;
    logic [SUM_W-1:0]    r_tat_sum;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_n;
    logic                r_pend;
    logic [IDX_W-1:0]    r_rd_slot;
    logic                r_found;
    logic [IDX_W-1:0]    r_best_slot;
    t_entry              r_best;
    logic                r_done;
    logic [TIME_W-1:0]   r_end;
    logic [TIME_W-1:0]   r_wt;
    logic [TIME_W-1:0]   r_tat;

    logic                r_o_valid;
    logic [TIME_W-1:0]   r_o_tick_time;
    logic                r_o_ran;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [ID_W-1:0]     r_o_id;
    logic                r_o_finished;
    logic [TIME_W-1:0]   r_o_wt;
    logic [TIME_W-1:0]   r_o_tat;
    logic                r_o_all_done;

    logic                accept;
    logic                load_ok;
    logic [XW-1:0]       slot_x;
    logic [XW-1:0]       pc_x;
    logic [CW-1:0]       n_calc;
    logic                scan_go;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    t_entry              rd_data;
    logic                cand_ok;
    logic                cand_better;
    logic [BURST_W-1:0]  rem_dec;
    logic [TIME_W-1:0]   end_t;
    logic [ARR_W:0]      need;
    logic [TIME_W-1:0]   arr_t;
    logic [TIME_W-1:0]   need_t;
    logic [TIME_W-1:0]   tat_c;
    logic [TIME_W-1:0]   wt_c;
    logic [CNT_W-1:0]    cnt_next;
    logic [SUM_W:0]      wsum_add;
    logic [SUM_W:0]      tsum_add;
    logic [SUM_W-1:0]    wsum_next;
    logic [SUM_W-1:0]    tsum_next;

    pps_table #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign accept  = start && !busy;
    assign slot_x  = XW'(i_slot);
    assign load_ok = slot_x < MAX_X;
    assign pc_x    = XW'(r_pc);
    assign n_calc  = (pc_x > MAX_X) ? CW'(MAX_X) : CW'(pc_x);
    assign scan_go = (r_state == ST_SCAN) && (r_idx < r_n);

    // shared compare unit: one table entry per cycle
    assign cand_ok     = r_pend && (rd_data.remaining != '0)
                         && (TIME_W'(rd_data.arrival) <= r_time);
    assign cand_better = cand_ok && (!r_found || (rd_data.pri < r_best.pri));

    // completion arithmetic
    assign rem_dec = r_best.remaining - BURST_W'(1);
    assign end_t   = (r_time == TIME_MAX) ? r_time : r_time + TIME_W'(1);
    assign need    = (ARR_W+1)'(r_best.arrival) + (ARR_W+1)'(r_best.burst);
    assign arr_t   = TIME_W'(r_best.arrival);
    assign need_t  = TIME_W'(need);
    assign tat_c   = (end_t > arr_t) ? end_t - arr_t : '0;
    assign wt_c    = (end_t > need_t) ? end_t - need_t : '0;

    // totals
    assign cnt_next  = (r_done && (r_count != COUNT_MAX)) ? r_count + CNT_W'(1) : r_count;
    assign wsum_add  = (SUM_W+1)'(r_wait_sum) + (SUM_W+1)'(r_wt);
    assign tsum_add  = (SUM_W+1)'(r_tat_sum) + (SUM_W+1)'(r_tat);
    assign wsum_next = wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
    assign tsum_next = tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == KIND_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!(r_idx < r_n)) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_SUM;
            ST_SUM:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy    = 1'b1;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_best_slot;
        wr_data = r_best;
        case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                wr_en   = accept && (i_kind == KIND_LOAD) && load_ok;
                wr_addr = IDX_W'(slot_x);
                wr_data = '{id: i_proc_id, burst: i_burst, arrival: i_arrival,
                            pri: i_priority_req, remaining: i_burst};
            end
            ST_SCAN: begin
                rd_en = scan_go;
            end
            ST_CALC: begin
                wr_en             = r_found;
                wr_data.remaining = rem_dec;
            end
            ST_SUM: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pc       <= PC_RESET;
            r_time     <= '0;
            r_count    <= '0;
            r_wait_sum <= '0;
            r_tat_sum  <= '0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_done     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc <= i_cfg_data;
            end
            r_pend <= scan_go;
            if (accept && (i_kind == KIND_TICK)) begin
                r_found <= 1'b0;
                r_done  <= 1'b0;
            end
            if (cand_better) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_CALC) begin
                r_done <= r_found && (rem_dec == '0);
            end
            if (r_state == ST_SUM) begin
                r_time    <= r_end;
                r_o_valid <= 1'b1;
                if (r_done) begin
                    r_count    <= cnt_next;
                    r_wait_sum <= wsum_next;
                    r_tat_sum  <= tsum_next;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && (i_kind == KIND_TICK)) begin
            r_idx <= '0;
            r_n   <= n_calc;
        end else if (scan_go) begin
            r_idx <= r_idx + CW'(1);
        end
        r_rd_slot <= r_idx[IDX_W-1:0];
        if (cand_better) begin
            r_best      <= rd_data;
            r_best_slot <= r_rd_slot;
        end
        if (r_state == ST_CALC) begin
            r_end <= end_t;
            r_wt  <= (r_found && (rem_dec == '0)) ? wt_c : '0;
            r_tat <= (r_found && (rem_dec == '0)) ? tat_c : '0;
        end
        if (r_state == ST_SUM) begin
            r_o_tick_time <= r_time;
            r_o_ran       <= r_found;
            r_o_slot      <= r_found ? SLOT_W'(r_best_slot) : '0;
            r_o_id        <= r_found ? r_best.id : '0;
            r_o_finished  <= r_done;
            r_o_wt        <= r_wt;
            r_o_tat       <= r_tat;
            r_o_all_done  <= XW'(cnt_next) >= XW'(r_n);
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_result_valid     = r_o_valid;
    assign o_tick_time        = r_o_tick_time;
    assign o_ran              = r_o_ran;
    assign o_chosen_slot      = r_o_slot;
    assign o_chosen_id        = r_o_id;
    assign o_finished         = r_o_finished;
    assign o_wait_time        = r_o_wt;
    assign o_turnaround       = r_o_tat;
    assign o_all_done         = r_o_all_done;
    assign o_total_wait       = r_wait_sum;
    assign o_total_turnaround = r_tat_sum;

    a_result_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == ST_SUM))
        else $error("result strobe without completed tick");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_n))
        else $error("scan index past slots in use");

    a_finish_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_finished) |-> o_ran)
        else $error("finished without a served process");

    a_wait_le_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_wt <= r_tat))
        else $error("waiting time exceeds turnaround");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !wr_en)
        else $error("table written during scan");

endmodule
`default_nettype wire

>>> sim/pps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker
// Watches the item, register and result channels of the priority scheduler.
// Keeps its own process table, works out the result of every accepted tick
// item and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module pps_checker
    import pps_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire logic                i_kind,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [ID_W-1:0]     i_proc_id,
    input  wire logic [BURST_W-1:0]  i_burst,
    input  wire logic [ARR_W-1:0]    i_arrival,
    input  wire logic [PRI_W-1:0]    i_priority_req,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [PC_W-1:0]     i_cfg_data,
    input  wire logic                i_result_valid,
    input  wire logic [TIME_W-1:0]   i_tick_time,
    input  wire logic                i_ran,
    input  wire logic [SLOT_W-1:0]   i_chosen_slot,
    input  wire logic [ID_W-1:0]     i_chosen_id,
    input  wire logic                i_finished,
    input  wire logic [TIME_W-1:0]   i_wait_time,
    input  wire logic [TIME_W-1:0]   i_turnaround,
    input  wire logic                i_all_done,
    input  wire logic [SUM_W-1:0]    i_total_wait,
    input  wire logic [SUM_W-1:0]    i_total_turnaround,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int SLOTS = MAX_PROCESSES_DEF;

    typedef struct {
        logic [TIME_W-1:0] tick_time;
        logic              ran;
        logic [SLOT_W-1:0] chosen_slot;
        logic [ID_W-1:0]   chosen_id;
        logic              finished;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround;
        logic              all_done;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_turnaround;
    } t_tick_result;

    logic [ID_W-1:0]    proc_id_tbl   [SLOTS];
    logic [BURST_W-1:0] burst_tbl     [SLOTS];
    logic [ARR_W-1:0]   arrival_tbl   [SLOTS];
    logic [PRI_W-1:0]   pri_tbl       [SLOTS];
    logic [BURST_W-1:0] remaining_tbl [SLOTS];
    logic [TIME_W-1:0]  now_time;
    logic [CNT_W-1:0]   done_count;
    logic [SUM_W-1:0]   wait_total;
    logic [SUM_W-1:0]   tat_total;
    logic [PC_W-1:0]    process_count;
    t_tick_result       expected_ticks[$];
    int                 fails = 0;

    assign o_fail_count = fails;

    // Picks the ready process with the smallest priority number (lowest slot
    // on a tie), serves it for one tick and advances time.
    function automatic t_tick_result serve_tick();
        t_tick_result    res;
        int unsigned     in_use;
        int unsigned     best;
        bit              found;
        longint unsigned end_t;
        longint unsigned need;
        longint unsigned wt;
        longint unsigned tat;
        longint unsigned acc;
        res = '{default: '0};
        in_use = (process_count > SLOTS) ? SLOTS : process_count;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < in_use; i++) begin
            if (remaining_tbl[i] != '0 && arrival_tbl[i] <= now_time &&
                (!found || pri_tbl[i] < pri_tbl[best])) begin
                found = 1'b1;
                best = i;
            end
        end
        res.tick_time = now_time;
        if (found) begin
            res.ran = 1'b1;
            res.chosen_slot = best[SLOT_W-1:0];
            res.chosen_id = proc_id_tbl[best];
            remaining_tbl[best] = remaining_tbl[best] - 1'b1;
            if (remaining_tbl[best] == '0) begin
                end_t = now_time;
                if (end_t < TIME_MAX) end_t++;
                need = arrival_tbl[best];
                need += burst_tbl[best];
                tat = (end_t > arrival_tbl[best]) ? end_t - arrival_tbl[best] : 0;
                wt = (end_t > need) ? end_t - need : 0;
                if (done_count != COUNT_MAX) done_count++;
                acc = wait_total;
                acc += wt;
                wait_total = (acc > SUM_MAX) ? SUM_MAX : SUM_W'(acc);
                acc = tat_total;
                acc += tat;
                tat_total = (acc > SUM_MAX) ? SUM_MAX : SUM_W'(acc);
                res.finished = 1'b1;
                res.wait_time = TIME_W'(wt);
                res.turnaround = TIME_W'(tat);
            end
        end
        if (now_time != TIME_MAX) now_time++;
        res.all_done = (done_count >= in_use);
        res.total_wait = wait_total;
        res.total_turnaround = tat_total;
        return res;
    endfunction

    function automatic void check_field(string name, logic [SUM_W-1:0] exp_v,
                                        logic [SUM_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                proc_id_tbl[i]   = '0;
                burst_tbl[i]     = '0;
                arrival_tbl[i]   = '0;
                pri_tbl[i]       = '0;
                remaining_tbl[i] = '0;
            end
            now_time      = '0;
            done_count    = '0;
            wait_total    = '0;
            tat_total     = '0;
            process_count = PC_RESET;
            expected_ticks.delete();
        end else begin
            if (i_result_valid) begin
                if (expected_ticks.size() == 0) begin
                    $error("result with tick_time %0d but no tick item waiting",
                           i_tick_time);
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("tick_time", want.tick_time, i_tick_time);
                    check_field("ran", want.ran, i_ran);
                    check_field("chosen_slot", want.chosen_slot, i_chosen_slot);
                    check_field("chosen_id", want.chosen_id, i_chosen_id);
                    check_field("finished", want.finished, i_finished);
                    check_field("wait_time", want.wait_time, i_wait_time);
                    check_field("turnaround", want.turnaround, i_turnaround);
                    check_field("all_done", want.all_done, i_all_done);
                    check_field("total_wait", want.total_wait, i_total_wait);
                    check_field("total_turnaround", want.total_turnaround,
                                i_total_turnaround);
                end
            end
            if (i_cfg_valid && i_cfg_ready) process_count = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_kind == KIND_LOAD) begin
                    if (int'(i_slot) < SLOTS) begin
                        proc_id_tbl[i_slot]   = i_proc_id;
                        burst_tbl[i_slot]     = i_burst;
                        arrival_tbl[i_slot]   = i_arrival;
                        pri_tbl[i_slot]       = i_priority_req;
                        remaining_tbl[i_slot] = i_burst;
                    end
                end else begin
                    expected_ticks.push_back(serve_tick());
                end
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and tick items and process_count writes into the priority
// scheduler: a directed opening, then random scheduling rounds with
// preemption, reloads and noise, and random sender gaps. Checking is done
// by pps_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pps_pkg::*;

    localparam int ITEMS = 450;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               item_kind = KIND_LOAD;
    logic [SLOT_W-1:0]  item_slot = '0;
    logic [ID_W-1:0]    item_id   = '0;
    logic [BURST_W-1:0] item_burst = '0;
    logic [ARR_W-1:0]   item_arrival = '0;
    logic [PRI_W-1:0]   item_pri  = '0;
    logic               cfg_valid = 1'b0;
    logic [PC_W-1:0]    cfg_data  = '0;

    logic               busy;
    logic               cfg_ready;
    logic               result_valid;
    logic [TIME_W-1:0]  tick_time;
    logic               ran;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [ID_W-1:0]    chosen_id;
    logic               finished;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround;
    logic               all_done;
    logic [SUM_W-1:0]   total_wait;
    logic [SUM_W-1:0]   total_turnaround;
    int                 fail_count;
    int                 pending;

    int unsigned        items_sent = 0;
    int unsigned        ticks_sent = 0;
    bit                 quiet = 1'b0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    preemptive_priority_scheduler u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .start              (start),
        .busy               (busy),
        .i_kind             (item_kind),
        .i_slot             (item_slot),
        .i_proc_id          (item_id),
        .i_burst            (item_burst),
        .i_arrival          (item_arrival),
        .i_priority_req     (item_pri),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_result_valid     (result_valid),
        .o_tick_time        (tick_time),
        .o_ran              (ran),
        .o_chosen_slot      (chosen_slot),
        .o_chosen_id        (chosen_id),
        .o_finished         (finished),
        .o_wait_time        (wait_time),
        .o_turnaround       (turnaround),
        .o_all_done         (all_done),
        .o_total_wait       (total_wait),
        .o_total_turnaround (total_turnaround)
    );

    pps_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_kind             (item_kind),
        .i_slot             (item_slot),
        .i_proc_id          (item_id),
        .i_burst            (item_burst),
        .i_arrival          (item_arrival),
        .i_priority_req     (item_pri),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .i_result_valid     (result_valid),
        .i_tick_time        (tick_time),
        .i_ran              (ran),
        .i_chosen_slot      (chosen_slot),
        .i_chosen_id        (chosen_id),
        .i_finished         (finished),
        .i_wait_time        (wait_time),
        .i_turnaround       (turnaround),
        .i_all_done         (all_done),
        .i_total_wait       (total_wait),
        .i_total_turnaround (total_turnaround),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Holds start high until the item is taken; start is only lowered by a gap or a drain.
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [ID_W-1:0] id, input logic [BURST_W-1:0] burst,
                             input logic [ARR_W-1:0] arr, input logic [PRI_W-1:0] pri);
        start        <= 1'b1;
        item_kind    <= kind;
        item_slot    <= slot;
        item_id      <= id;
        item_burst   <= burst;
        item_arrival <= arr;
        item_pri     <= pri;
        do @(posedge clk); while (busy);
        items_sent++;
        if (kind == KIND_TICK) ticks_sent++;
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] burst, input logic [ARR_W-1:0] arr,
                             input logic [PRI_W-1:0] pri);
        send_item(KIND_LOAD, slot, id, burst, arr, pri);
    endtask

    // Payload of a tick item is don't-care, so it carries noise.
    task automatic tick();
        send_item(KIND_TICK, SLOT_W'($urandom), ID_W'($urandom), BURST_W'($urandom),
                  ARR_W'($urandom), PRI_W'($urandom));
    endtask

    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else if (r < 97) n = $urandom_range(4, 8);
        else n = $urandom_range(15, 40);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_process_count(input logic [PC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BURST_W-1:0] rand_burst();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 87) return BURST_W'($urandom_range(1, 6));
        else if (r < 92) return '0;
        else if (r < 98) return BURST_W'($urandom_range(7, 40));
        return BURST_W'($urandom);
    endfunction

    // Mostly arrivals close to the current tick so processes become ready soon.
    function automatic logic [ARR_W-1:0] rand_arrival();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return ARR_W'(ticks_sent + $urandom_range(0, 6));
        else if (r < 90) return ARR_W'($urandom_range(0, ticks_sent));
        else if (r < 95) return '1;
        return ARR_W'($urandom);
    endfunction

    function automatic logic [PRI_W-1:0] rand_pri();
        if ($urandom_range(0, 1) == 0) return PRI_W'($urandom_range(0, 3));
        return PRI_W'($urandom);
    endfunction

    initial begin
        int unsigned r;
        int unsigned pc_val;
        int unsigned in_use;
        int unsigned work;
        int unsigned n_ticks;
        logic [BURST_W-1:0] b;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot with a zero-burst entry: defined, never ready.
        for (int s = 0; s < MAX_PROCESSES_DEF; s++) begin
            load_slot(SLOT_W'(s), s[0] ? '1 : '0, '0, s[1] ? '1 : '0, s[2] ? '1 : '0);
        end
        tick();                                     // idle tick, slot 0 has no work
        load_slot('0, '1, BURST_W'(1), '0, '1);
        tick();                                     // single-tick process finishes
        tick();                                     // tick after all done
        drain();
        write_process_count('0);                    // no slot in use
        tick();
        drain();
        write_process_count('1);                    // above table size, clamps
        load_slot(SLOT_W'(1), ID_W'(8'h5a), '1, '1, '0);   // never arrives
        load_slot(SLOT_W'(2), ID_W'(8'h11), BURST_W'(2), '0, PRI_W'(7));
        load_slot(SLOT_W'(3), ID_W'(8'h22), BURST_W'(1), '0, PRI_W'(7));  // tie
        load_slot('1, ID_W'(8'h33), BURST_W'(1), '0, PRI_W'(3));
        repeat (5) tick();

        while (items_sent < ITEMS) begin
            drain();
            r = $urandom_range(0, 99);
            if (r < 8) pc_val = 0;
            else if (r < 16) pc_val = 1;
            else if (r < 26) pc_val = MAX_PROCESSES_DEF;
            else if (r < 31) pc_val = 31;
            else if (r < 36) pc_val = $urandom_range(MAX_PROCESSES_DEF + 1, 30);
            else pc_val = $urandom_range(2, MAX_PROCESSES_DEF - 1);
            write_process_count(PC_W'(pc_val));
            in_use = (pc_val > MAX_PROCESSES_DEF) ? MAX_PROCESSES_DEF : pc_val;
            quiet = ($urandom_range(0, 4) == 0);
            work = 0;
            for (int s = 0; s < in_use; s++) begin
                b = rand_burst();
                load_slot(SLOT_W'(s), ID_W'($urandom), b, rand_arrival(), rand_pri());
                if (b <= 40) work += b;
                sender_gap();
            end
            n_ticks = work + $urandom_range(1, 6);
            if (n_ticks > 120) n_ticks = 120;
            repeat (n_ticks) begin
                r = $urandom_range(0, 99);
                if (r < 6 && in_use != 0) begin
                    // new arrival into a live slot, may preempt the running one
                    load_slot(SLOT_W'($urandom_range(0, in_use - 1)), ID_W'($urandom),
                              rand_burst(), rand_arrival(), rand_pri());
                    sender_gap();
                end else if (r < 9) begin
                    load_slot(SLOT_W'($urandom), ID_W'($urandom), BURST_W'($urandom),
                              ARR_W'($urandom), PRI_W'($urandom));
                    sender_gap();
                end else if (r < 11) begin
                    drain();
                end
                tick();
                sender_gap();
            end
        end

        drain();
        repeat (25) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pps_pkg.sv
rtl/core/pps_table.sv
rtl/core/preemptive_priority_scheduler.sv
sim/pps_checker.sv
sim/testbench.sv
